FILE: rtl/i2cram_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C register access master.
// Used by i2c_register_access_master; depends on nothing else.
package i2cram_pkg;

   typedef enum logic [4:0] {
      P_IDLE     = 5'd0,
      P_ST_A     = 5'd1,
      P_ST_B     = 5'd2,
      P_ST_C     = 5'd3,
      P_TX_LOW   = 5'd4,
      P_TX_HIGH  = 5'd5,
      P_ACK_LOW  = 5'd6,
      P_ACK_HIGH = 5'd7,
      P_ACK_POLL = 5'd8,
      P_ACK_END  = 5'd9,
      P_RX_HIGH  = 5'd10,
      P_RX_LOW   = 5'd11,
      P_MA_LOW   = 5'd12,
      P_MA_HIGH  = 5'd13,
      P_MA_END   = 5'd14,
      P_SP_A     = 5'd15,
      P_SP_B     = 5'd16,
      P_SP_C     = 5'd17,
      P_EP_A     = 5'd18,
      P_EP_B     = 5'd19,
      P_EP_C     = 5'd20
   } phase_type;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_WRITE = 2'd1;
   localparam opcode_type OP_READ  = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_DEVICE_ADDRESS = 2'd0;
   localparam csr_index_type CSR_ACK_TIMEOUT    = 2'd1;
   localparam csr_index_type CSR_PHASE_TICKS    = 2'd2;

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h38;
   localparam logic [9:0] ACK_TIMEOUT_RESET    = 10'd250;
   localparam logic [9:0] PHASE_TICKS_RESET    = 10'd80;

   localparam logic [4:0] BYTE_REGISTER = 5'd1;
   localparam logic [4:0] BYTE_VALUE    = 5'd2;
   localparam logic [2:0] LAST_BIT      = 3'd7;

endpackage

FILE: rtl/i2c_register_access_master.sv
`timescale 1ns / 1ps
// I2C register access master: phase sequencer, configuration registers and result register.
// Depends on i2cram_pkg.
//
// Each beat on the req_ channel is one bus tick and may carry a command:
// register write (opcode 1) or register read (opcode 2) of read_count bytes, at most MAX_READ_BYTES.
// Commands that arrive while a transaction is running are ignored.
// Each accepted beat yields exactly one rsp_ beat with the SCL and SDA levels
// in force at the start of that tick, busy, received byte and done flags.
// The state machine advances and the result register loads at the edge that
// accepts the beat. Throughput is one beat per cycle while results are taken;
// the single result register sets that figure, and req_ready stays high while
// that register is empty or being taken.
// When rsp_ready is low with a result pending, req_ready drops and the
// sequencer holds its state until the result is taken.
// Reset returns the sequencer to idle, clears counters and loads the
// configuration defaults: address 0x38, ack timeout 250, phase ticks 80.
// Configuration is written through the csr_ APB port at byte addresses
// 0, 4 and 8, with a setup phase and an access phase; csr_pready is always high.
module i2c_register_access_master #(
   parameter int MAX_READ_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_write_value,
   input  logic [4:0]  req_read_count,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_last_byte,
   output logic        rsp_done_res,
   output logic        rsp_ack_error,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [7:0] MaxCount = 8'(MAX_READ_BYTES);

   logic [6:0]  device_address_ff;
   logic [9:0]  ack_timeout_ff;
   logic [9:0]  phase_ticks_ff;

   i2cram_pkg::phase_type phase_state_ff, phase_state_in;
   logic [2:0]  bit_counter_ff, bit_counter_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [4:0]  byte_counter_ff, byte_counter_in;
   logic [9:0]  wait_counter_ff, wait_counter_in;
   logic [9:0]  tick_divider_ff, tick_divider_in;
   logic [7:0]  held_register_ff, held_register_in;
   logic [7:0]  held_value_ff, held_value_in;
   logic [4:0]  held_count_ff, held_count_in;
   logic        held_is_read_ff, held_is_read_in;

   logic        rsp_valid_ff;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        busy_ff, busy_in;
   logic        bv_ff, bv_in;
   logic [7:0]  rd_ff, rd_in;
   logic        lb_ff, lb_in;
   logic        done_ff, done_in;
   logic        err_ff, err_in;

   logic        accept;
   logic        csr_write;
   i2cram_pkg::csr_index_type csr_index;
   logic [9:0]  phase_limit;
   logic        phase_over;
   logic [9:0]  divider_step;
   logic        final_rx;
   logic        txbit;
   logic        start_cmd;
   logic [7:0]  count_wide;
   logic [4:0]  count_sat;
   logic [7:0]  rx_shift;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      unique case (csr_index)
         i2cram_pkg::CSR_DEVICE_ADDRESS: csr_prdata = {25'd0, device_address_ff};
         i2cram_pkg::CSR_ACK_TIMEOUT:    csr_prdata = {22'd0, ack_timeout_ff};
         i2cram_pkg::CSR_PHASE_TICKS:    csr_prdata = {22'd0, phase_ticks_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= i2cram_pkg::DEVICE_ADDRESS_RESET;
         ack_timeout_ff    <= i2cram_pkg::ACK_TIMEOUT_RESET;
         phase_ticks_ff    <= i2cram_pkg::PHASE_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            i2cram_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_pwdata[6:0];
            i2cram_pkg::CSR_ACK_TIMEOUT:    ack_timeout_ff    <= csr_pwdata[9:0];
            i2cram_pkg::CSR_PHASE_TICKS:    phase_ticks_ff    <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   assign phase_limit  = (phase_ticks_ff == 10'd0) ? 10'd1 : phase_ticks_ff;
   assign phase_over   = ({1'b0, tick_divider_ff} + 11'd1) >= {1'b0, phase_limit};
   assign divider_step = phase_over ? 10'd0 : tick_divider_ff + 10'd1;
   assign final_rx     = ({1'b0, byte_counter_ff} + 6'd1) >= {1'b0, held_count_ff};
   assign txbit        = shift_byte_ff[7];
   assign start_cmd    = (req_opcode == i2cram_pkg::OP_WRITE) ||
                         ((req_opcode == i2cram_pkg::OP_READ) && (req_read_count != 5'd0));
   assign count_wide   = {3'd0, req_read_count};
   assign count_sat    = (count_wide > MaxCount) ? MaxCount[4:0] : req_read_count;
   assign rx_shift     = {shift_byte_ff[6:0], req_sda_in};

   always_comb begin
      phase_state_in   = phase_state_ff;
      bit_counter_in   = bit_counter_ff;
      shift_byte_in    = shift_byte_ff;
      byte_counter_in  = byte_counter_ff;
      wait_counter_in  = wait_counter_ff;
      tick_divider_in  = tick_divider_ff;
      held_register_in = held_register_ff;
      held_value_in    = held_value_ff;
      held_count_in    = held_count_ff;
      held_is_read_in  = held_is_read_ff;
      scl_in  = 1'b1;
      sda_in  = 1'b1;
      busy_in = 1'b1;
      bv_in   = 1'b0;
      rd_in   = 8'd0;
      lb_in   = 1'b0;
      done_in = 1'b0;
      err_in  = 1'b0;

      unique case (phase_state_ff)
         i2cram_pkg::P_IDLE: begin
            busy_in = start_cmd;
            if (start_cmd) begin
               held_register_in = req_reg_addr;
               held_value_in    = req_write_value;
               held_is_read_in  = (req_opcode == i2cram_pkg::OP_READ);
               held_count_in    = count_sat;
               byte_counter_in  = 5'd0;
               bit_counter_in   = 3'd0;
               wait_counter_in  = 10'd0;
               tick_divider_in  = 10'd0;
               phase_state_in   = i2cram_pkg::P_ST_A;
            end
         end
         i2cram_pkg::P_ST_A: begin
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_ST_B;
         end
         i2cram_pkg::P_ST_B: begin
            sda_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_ST_C;
         end
         i2cram_pkg::P_ST_C: begin
            scl_in = 1'b0;
            sda_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) begin
               shift_byte_in  = {device_address_ff, byte_counter_ff == i2cram_pkg::BYTE_VALUE};
               bit_counter_in = 3'd0;
               phase_state_in = i2cram_pkg::P_TX_LOW;
            end
         end
         i2cram_pkg::P_TX_LOW: begin
            scl_in = 1'b0;
            sda_in = txbit;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_TX_HIGH;
         end
         i2cram_pkg::P_TX_HIGH: begin
            sda_in = txbit;
            tick_divider_in = divider_step;
            if (phase_over) begin
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               if (bit_counter_ff == i2cram_pkg::LAST_BIT) begin
                  bit_counter_in = 3'd0;
                  phase_state_in = i2cram_pkg::P_ACK_LOW;
               end else begin
                  bit_counter_in = bit_counter_ff + 3'd1;
                  phase_state_in = i2cram_pkg::P_TX_LOW;
               end
            end
         end
         i2cram_pkg::P_ACK_LOW: begin
            scl_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_ACK_HIGH;
         end
         i2cram_pkg::P_ACK_HIGH: begin
            tick_divider_in = divider_step;
            if (phase_over) begin
               wait_counter_in = 10'd0;
               phase_state_in  = i2cram_pkg::P_ACK_POLL;
            end
         end
         i2cram_pkg::P_ACK_POLL: begin
            if (!req_sda_in) begin
               wait_counter_in = 10'd0;
               tick_divider_in = 10'd0;
               phase_state_in  = i2cram_pkg::P_ACK_END;
            end else if (wait_counter_ff >= ack_timeout_ff) begin
               wait_counter_in = 10'd0;
               tick_divider_in = 10'd0;
               phase_state_in  = i2cram_pkg::P_EP_A;
            end else begin
               wait_counter_in = wait_counter_ff + 10'd1;
            end
         end
         i2cram_pkg::P_ACK_END: begin
            scl_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) begin
               bit_counter_in = 3'd0;
               if (byte_counter_ff == 5'd0) begin
                  shift_byte_in   = held_register_ff;
                  byte_counter_in = i2cram_pkg::BYTE_REGISTER;
                  phase_state_in  = i2cram_pkg::P_TX_LOW;
               end else if (!held_is_read_ff) begin
                  if (byte_counter_ff == i2cram_pkg::BYTE_REGISTER) begin
                     shift_byte_in   = held_value_ff;
                     byte_counter_in = i2cram_pkg::BYTE_VALUE;
                     phase_state_in  = i2cram_pkg::P_TX_LOW;
                  end else begin
                     phase_state_in  = i2cram_pkg::P_SP_A;
                  end
               end else if (byte_counter_ff == i2cram_pkg::BYTE_REGISTER) begin
                  byte_counter_in = i2cram_pkg::BYTE_VALUE;
                  phase_state_in  = i2cram_pkg::P_ST_A;
               end else begin
                  byte_counter_in = 5'd0;
                  shift_byte_in   = 8'd0;
                  phase_state_in  = i2cram_pkg::P_RX_HIGH;
               end
            end
         end
         i2cram_pkg::P_RX_HIGH: begin
            tick_divider_in = divider_step;
            if (phase_over) begin
               shift_byte_in = rx_shift;
               if (bit_counter_ff == i2cram_pkg::LAST_BIT) begin
                  bit_counter_in = 3'd0;
                  bv_in = 1'b1;
                  rd_in = rx_shift;
                  lb_in = final_rx;
               end else begin
                  bit_counter_in = bit_counter_ff + 3'd1;
               end
               phase_state_in = i2cram_pkg::P_RX_LOW;
            end
         end
         i2cram_pkg::P_RX_LOW: begin
            scl_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) begin
               phase_state_in = (bit_counter_ff == 3'd0) ? i2cram_pkg::P_MA_LOW
                                                         : i2cram_pkg::P_RX_HIGH;
            end
         end
         i2cram_pkg::P_MA_LOW: begin
            scl_in = 1'b0;
            sda_in = final_rx;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_MA_HIGH;
         end
         i2cram_pkg::P_MA_HIGH: begin
            sda_in = final_rx;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_MA_END;
         end
         i2cram_pkg::P_MA_END: begin
            scl_in = 1'b0;
            sda_in = final_rx;
            tick_divider_in = divider_step;
            if (phase_over) begin
               byte_counter_in = byte_counter_ff + 5'd1;
               bit_counter_in  = 3'd0;
               phase_state_in  = final_rx ? i2cram_pkg::P_SP_A : i2cram_pkg::P_RX_HIGH;
            end
         end
         i2cram_pkg::P_SP_A: begin
            scl_in = 1'b0;
            sda_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_SP_B;
         end
         i2cram_pkg::P_SP_B: begin
            sda_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_SP_C;
         end
         i2cram_pkg::P_SP_C: begin
            tick_divider_in = divider_step;
            if (phase_over) begin
               done_in = 1'b1;
               phase_state_in = i2cram_pkg::P_IDLE;
            end
         end
         i2cram_pkg::P_EP_A: begin
            scl_in = 1'b0;
            sda_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_EP_B;
         end
         i2cram_pkg::P_EP_B: begin
            sda_in = 1'b0;
            tick_divider_in = divider_step;
            if (phase_over) phase_state_in = i2cram_pkg::P_EP_C;
         end
         i2cram_pkg::P_EP_C: begin
            tick_divider_in = divider_step;
            if (phase_over) begin
               done_in = 1'b1;
               err_in  = 1'b1;
               phase_state_in = i2cram_pkg::P_IDLE;
            end
         end
         default: begin
            phase_state_in  = i2cram_pkg::P_IDLE;
            tick_divider_in = 10'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_state_ff   <= i2cram_pkg::P_IDLE;
         bit_counter_ff   <= 3'd0;
         shift_byte_ff    <= 8'd0;
         byte_counter_ff  <= 5'd0;
         wait_counter_ff  <= 10'd0;
         tick_divider_ff  <= 10'd0;
         held_register_ff <= 8'd0;
         held_value_ff    <= 8'd0;
         held_count_ff    <= 5'd0;
         held_is_read_ff  <= 1'b0;
      end else if (accept) begin
         phase_state_ff   <= phase_state_in;
         bit_counter_ff   <= bit_counter_in;
         shift_byte_ff    <= shift_byte_in;
         byte_counter_ff  <= byte_counter_in;
         wait_counter_ff  <= wait_counter_in;
         tick_divider_ff  <= tick_divider_in;
         held_register_ff <= held_register_in;
         held_value_ff    <= held_value_in;
         held_count_ff    <= held_count_in;
         held_is_read_ff  <= held_is_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff  <= scl_in;
         sda_ff  <= sda_in;
         busy_ff <= busy_in;
         bv_ff   <= bv_in;
         rd_ff   <= rd_in;
         lb_ff   <= lb_in;
         done_ff <= done_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = scl_ff;
   assign rsp_sda_level  = sda_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_read_data  = rd_ff;
   assign rsp_last_byte  = lb_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_ack_error  = err_ff;

endmodule

FILE: dv/i2c_register_access_master_test.sv
`timescale 1ns / 1ps
// Self-checking test of i2c_register_access_master: random and directed bus ticks, APB setup.
// Depends on i2cram_pkg and the i2c_register_access_master RTL; expected lines come from
// a cycle model of the phase sequencer kept in this file.
module i2c_register_access_master_test;

   localparam int READ_BURST_LIMIT = 16;
   localparam i2cram_pkg::opcode_type OP_SPARE = 2'd3;

   typedef struct packed {
      i2cram_pkg::opcode_type opcode;
      logic [7:0] reg_addr;
      logic [7:0] write_value;
      logic [4:0] read_count;
      logic       sda_in;
   } bus_tick_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] read_data;
      logic       last_byte;
      logic       done_res;
      logic       ack_error;
   } bus_levels_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = i2cram_pkg::OP_TICK;
   logic [7:0]  req_reg_addr = '0;
   logic [7:0]  req_write_value = '0;
   logic [4:0]  req_read_count = '0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_byte_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_last_byte;
   logic        rsp_done_res;
   logic        rsp_ack_error;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bus_tick_type   tick_plan[$];
   bus_levels_type expected_levels[$];
   bit          req_taken = 1'b0;
   int          req_gap_pct = 33;
   int          rsp_stall_pct = 33;
   int unsigned failures = 0;

   logic [6:0]  cfg_device = i2cram_pkg::DEVICE_ADDRESS_RESET;
   logic [9:0]  cfg_timeout = i2cram_pkg::ACK_TIMEOUT_RESET;
   logic [9:0]  cfg_half = i2cram_pkg::PHASE_TICKS_RESET;

   i2cram_pkg::phase_type phase_now = i2cram_pkg::P_IDLE;
   logic [2:0]  bit_index = '0;
   logic [7:0]  shift_reg = '0;
   logic [4:0]  byte_index = '0;
   logic [9:0]  poll_count = '0;
   logic [9:0]  half_count = '0;
   logic [7:0]  pending_reg = '0;
   logic [7:0]  pending_value = '0;
   logic [4:0]  pending_count = '0;
   logic        pending_read = 1'b0;

   i2c_register_access_master #(.MAX_READ_BYTES(READ_BURST_LIMIT)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_reg_addr(req_reg_addr), .req_write_value(req_write_value),
      .req_read_count(req_read_count), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_scl_level(rsp_scl_level),
      .rsp_sda_level(rsp_sda_level), .rsp_busy_res(rsp_busy_res),
      .rsp_byte_valid(rsp_byte_valid), .rsp_read_data(rsp_read_data),
      .rsp_last_byte(rsp_last_byte), .rsp_done_res(rsp_done_res),
      .rsp_ack_error(rsp_ack_error),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   function automatic bit half_phase_elapsed();
      int unsigned limit;
      limit = (cfg_half == 0) ? 1 : cfg_half;
      if (half_count + 1 >= limit) begin
         half_count = '0;
         return 1'b1;
      end
      half_count = half_count + 1'b1;
      return 1'b0;
   endfunction

   function automatic bit final_byte();
      return (int'(byte_index) + 1 >= int'(pending_count));
   endfunction

   function automatic bus_levels_type sequence_tick(bus_tick_type t);
      bus_levels_type o;
      bit          tx_bit;
      bit          fin;
      o = '0;
      o.scl_level = 1'b1;
      o.sda_level = 1'b1;
      o.busy_res = 1'b1;
      tx_bit = shift_reg[7];

      case (phase_now) inside
         i2cram_pkg::P_ST_B: o.sda_level = 1'b0;
         i2cram_pkg::P_ST_C, i2cram_pkg::P_SP_A, i2cram_pkg::P_EP_A: begin
            o.scl_level = 1'b0;
            o.sda_level = 1'b0;
         end
         i2cram_pkg::P_TX_LOW: begin
            o.scl_level = 1'b0;
            o.sda_level = tx_bit;
         end
         i2cram_pkg::P_TX_HIGH: o.sda_level = tx_bit;
         i2cram_pkg::P_ACK_LOW, i2cram_pkg::P_ACK_END, i2cram_pkg::P_RX_LOW:
            o.scl_level = 1'b0;
         i2cram_pkg::P_MA_LOW, i2cram_pkg::P_MA_END: begin
            o.scl_level = 1'b0;
            o.sda_level = final_byte();
         end
         i2cram_pkg::P_MA_HIGH: o.sda_level = final_byte();
         i2cram_pkg::P_SP_B, i2cram_pkg::P_EP_B: o.sda_level = 1'b0;
         i2cram_pkg::P_IDLE: o.busy_res = 1'b0;
         default: ;
      endcase

      case (phase_now)
         i2cram_pkg::P_IDLE: begin
            if (t.opcode == i2cram_pkg::OP_WRITE ||
                (t.opcode == i2cram_pkg::OP_READ && t.read_count != 0)) begin
               pending_reg = t.reg_addr;
               pending_value = t.write_value;
               pending_read = (t.opcode == i2cram_pkg::OP_READ);
               pending_count = (t.read_count > READ_BURST_LIMIT) ?
                               5'(READ_BURST_LIMIT) : t.read_count;
               byte_index = '0;
               bit_index = '0;
               poll_count = '0;
               half_count = '0;
               phase_now = i2cram_pkg::P_ST_A;
               o.busy_res = 1'b1;
            end
         end
         i2cram_pkg::P_ST_A: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_ST_B;
         i2cram_pkg::P_ST_B: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_ST_C;
         i2cram_pkg::P_ST_C: begin
            if (half_phase_elapsed()) begin
               shift_reg = {cfg_device, byte_index == i2cram_pkg::BYTE_VALUE};
               bit_index = '0;
               phase_now = i2cram_pkg::P_TX_LOW;
            end
         end
         i2cram_pkg::P_TX_LOW: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_TX_HIGH;
         i2cram_pkg::P_TX_HIGH: begin
            if (half_phase_elapsed()) begin
               shift_reg = {shift_reg[6:0], 1'b0};
               if (bit_index >= i2cram_pkg::LAST_BIT) begin
                  bit_index = '0;
                  phase_now = i2cram_pkg::P_ACK_LOW;
               end else begin
                  bit_index = bit_index + 1'b1;
                  phase_now = i2cram_pkg::P_TX_LOW;
               end
            end
         end
         i2cram_pkg::P_ACK_LOW: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_ACK_HIGH;
         i2cram_pkg::P_ACK_HIGH: begin
            if (half_phase_elapsed()) begin
               poll_count = '0;
               phase_now = i2cram_pkg::P_ACK_POLL;
            end
         end
         i2cram_pkg::P_ACK_POLL: begin
            if (!t.sda_in) begin
               poll_count = '0;
               half_count = '0;
               phase_now = i2cram_pkg::P_ACK_END;
            end else if (poll_count >= cfg_timeout) begin
               poll_count = '0;
               half_count = '0;
               phase_now = i2cram_pkg::P_EP_A;
            end else begin
               poll_count = poll_count + 1'b1;
            end
         end
         i2cram_pkg::P_ACK_END: begin
            if (half_phase_elapsed()) begin
               bit_index = '0;
               if (byte_index == 0) begin
                  shift_reg = pending_reg;
                  byte_index = i2cram_pkg::BYTE_REGISTER;
                  phase_now = i2cram_pkg::P_TX_LOW;
               end else if (!pending_read) begin
                  if (byte_index == i2cram_pkg::BYTE_REGISTER) begin
                     shift_reg = pending_value;
                     byte_index = i2cram_pkg::BYTE_VALUE;
                     phase_now = i2cram_pkg::P_TX_LOW;
                  end else begin
                     phase_now = i2cram_pkg::P_SP_A;
                  end
               end else if (byte_index == i2cram_pkg::BYTE_REGISTER) begin
                  byte_index = i2cram_pkg::BYTE_VALUE;
                  phase_now = i2cram_pkg::P_ST_A;
               end else begin
                  byte_index = '0;
                  shift_reg = '0;
                  phase_now = i2cram_pkg::P_RX_HIGH;
               end
            end
         end
         i2cram_pkg::P_RX_HIGH: begin
            if (half_phase_elapsed()) begin
               shift_reg = {shift_reg[6:0], t.sda_in};
               if (bit_index >= i2cram_pkg::LAST_BIT) begin
                  bit_index = '0;
                  o.byte_valid = 1'b1;
                  o.read_data = shift_reg;
                  o.last_byte = final_byte();
               end else begin
                  bit_index = bit_index + 1'b1;
               end
               phase_now = i2cram_pkg::P_RX_LOW;
            end
         end
         i2cram_pkg::P_RX_LOW: begin
            if (half_phase_elapsed()) begin
               phase_now = (bit_index == 0) ? i2cram_pkg::P_MA_LOW : i2cram_pkg::P_RX_HIGH;
            end
         end
         i2cram_pkg::P_MA_LOW: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_MA_HIGH;
         i2cram_pkg::P_MA_HIGH: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_MA_END;
         i2cram_pkg::P_MA_END: begin
            if (half_phase_elapsed()) begin
               fin = final_byte();
               byte_index = byte_index + 1'b1;
               bit_index = '0;
               phase_now = fin ? i2cram_pkg::P_SP_A : i2cram_pkg::P_RX_HIGH;
            end
         end
         i2cram_pkg::P_SP_A: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_SP_B;
         i2cram_pkg::P_SP_B: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_SP_C;
         i2cram_pkg::P_SP_C: begin
            if (half_phase_elapsed()) begin
               o.done_res = 1'b1;
               phase_now = i2cram_pkg::P_IDLE;
            end
         end
         i2cram_pkg::P_EP_A: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_EP_B;
         i2cram_pkg::P_EP_B: if (half_phase_elapsed()) phase_now = i2cram_pkg::P_EP_C;
         i2cram_pkg::P_EP_C: begin
            if (half_phase_elapsed()) begin
               o.done_res = 1'b1;
               o.ack_error = 1'b1;
               phase_now = i2cram_pkg::P_IDLE;
            end
         end
         default: begin
            phase_now = i2cram_pkg::P_IDLE;
            half_count = '0;
         end
      endcase
      return o;
   endfunction

   function automatic bus_tick_type random_tick(int cmd_pct, int sda_high_pct);
      bus_tick_type t;
      int        roll;
      roll = $urandom_range(99);
      if (roll < cmd_pct / 2) t.opcode = i2cram_pkg::OP_WRITE;
      else if (roll < cmd_pct) t.opcode = i2cram_pkg::OP_READ;
      else if (roll >= 95) t.opcode = OP_SPARE;
      else t.opcode = i2cram_pkg::OP_TICK;
      t.reg_addr = 8'($urandom_range(255));
      t.write_value = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) t.read_count = 5'($urandom_range(31));
      else t.read_count = 5'($urandom_range(4, 1));
      t.sda_in = ($urandom_range(99) < sda_high_pct);
      return t;
   endfunction

   task automatic report_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (tick_plan.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
            {req_opcode, req_reg_addr, req_write_value, req_read_count, req_sda_in}
               <= tick_plan.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      bus_levels_type want;
      bus_levels_type got;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_byte_valid,
                   rsp_read_data, rsp_last_byte, rsp_done_res, rsp_ack_error};
            if (expected_levels.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual %0h", $time, got);
               failures++;
            end else begin
               want = expected_levels.pop_front();
               report_field("scl_level", int'(want.scl_level), int'(got.scl_level));
               report_field("sda_level", int'(want.sda_level), int'(got.sda_level));
               report_field("busy_res", int'(want.busy_res), int'(got.busy_res));
               report_field("byte_valid", int'(want.byte_valid), int'(got.byte_valid));
               report_field("read_data", int'(want.read_data), int'(got.read_data));
               report_field("last_byte", int'(want.last_byte), int'(got.last_byte));
               report_field("done_res", int'(want.done_res), int'(got.done_res));
               report_field("ack_error", int'(want.ack_error), int'(got.ack_error));
            end
         end
         if (req_valid && req_ready) begin
            expected_levels.push_back(sequence_tick({req_opcode, req_reg_addr,
               req_write_value, req_read_count, req_sda_in}));
            req_taken = 1'b1;
         end
      end
   end

   task automatic csr_check(i2cram_pkg::csr_index_type idx);
      logic [31:0] want;
      logic [31:0] got;
      case (idx)
         i2cram_pkg::CSR_DEVICE_ADDRESS: want = {25'd0, cfg_device};
         i2cram_pkg::CSR_ACK_TIMEOUT: want = {22'd0, cfg_timeout};
         default: want = {22'd0, cfg_half};
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got != want) begin
         $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                  $time, idx, want, got);
         failures++;
      end
   endtask

   task automatic csr_write(i2cram_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         i2cram_pkg::CSR_DEVICE_ADDRESS: cfg_device = value[6:0];
         i2cram_pkg::CSR_ACK_TIMEOUT: cfg_timeout = value[9:0];
         default: cfg_half = value[9:0];
      endcase
      csr_check(idx);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (tick_plan.size() != 0 || req_valid || expected_levels.size() != 0);
   endtask

   task automatic run_random(int count, int cmd_pct, int sda_high_pct);
      for (int n = 0; n < count; n++) tick_plan.push_back(random_tick(cmd_pct, sda_high_pct));
      drain();
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      csr_check(i2cram_pkg::CSR_DEVICE_ADDRESS);
      csr_check(i2cram_pkg::CSR_ACK_TIMEOUT);
      csr_check(i2cram_pkg::CSR_PHASE_TICKS);

      // Ignored commands at idle, then a write, then commands that land while busy.
      tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_TICK, 8'h00, 8'h00, 5'd0, 1'b1});
      tick_plan.push_back(bus_tick_type'{OP_SPARE, 8'hFF, 8'hFF, 5'd31, 1'b0});
      tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_READ, 8'hFF, 8'hFF, 5'd0, 1'b1});
      tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_WRITE, 8'hFF, 8'h00, 5'd0, 1'b0});
      tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_READ, 8'h00, 8'hFF, 5'd31, 1'b1});
      tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_WRITE, 8'h00, 8'hFF, 5'd16, 1'b0});
      tick_plan.push_back(bus_tick_type'{OP_SPARE, 8'h5A, 8'hA5, 5'd15, 1'b1});
      tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_READ, 8'hAA, 8'h55, 5'd1, 1'b0});
      drain();

      // Change the timing and the device address in the middle of the running write.
      csr_write(i2cram_pkg::CSR_PHASE_TICKS, 32'd0);
      csr_write(i2cram_pkg::CSR_ACK_TIMEOUT, 32'd0);
      csr_write(i2cram_pkg::CSR_DEVICE_ADDRESS, 32'h7F);
      for (int i = 0; i < 12; i++) begin
         tick_plan.push_back(bus_tick_type'{i2cram_pkg::OP_TICK, 8'(i), 8'hFF, 5'd31, i[0]});
      end
      run_random(200, 16, 50);

      req_gap_pct = 0;
      rsp_stall_pct = 0;
      csr_write(i2cram_pkg::CSR_PHASE_TICKS, 32'd1);
      csr_write(i2cram_pkg::CSR_ACK_TIMEOUT, 32'd3);
      csr_write(i2cram_pkg::CSR_DEVICE_ADDRESS, 32'h00);
      run_random(250, 16, 50);
      req_gap_pct = 33;
      rsp_stall_pct = 33;

      csr_write(i2cram_pkg::CSR_PHASE_TICKS, 32'd2);
      csr_write(i2cram_pkg::CSR_ACK_TIMEOUT, 32'd1023);
      csr_write(i2cram_pkg::CSR_DEVICE_ADDRESS, 32'($urandom_range(127)));
      run_random(200, 16, 50);

      csr_write(i2cram_pkg::CSR_PHASE_TICKS, 32'd1);
      csr_write(i2cram_pkg::CSR_ACK_TIMEOUT, 32'd7);
      run_random(100, 16, 90);

      csr_write(i2cram_pkg::CSR_PHASE_TICKS, 32'd1023);
      csr_write(i2cram_pkg::CSR_ACK_TIMEOUT, 32'd1);
      run_random(40, 16, 50);

      csr_write(i2cram_pkg::CSR_PHASE_TICKS, 32'd3);
      csr_write(i2cram_pkg::CSR_ACK_TIMEOUT, 32'd2);
      csr_write(i2cram_pkg::CSR_DEVICE_ADDRESS, 32'($urandom_range(127)));
      run_random(250, 16, 50);

      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: run did not finish in time", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
